// ----- src/plti_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_pkg - shared types and codes for the piecewise linear table interpolator
// Operation and status codes, plus the request and response bundles of the
// iterative divide unit.
// ----------------------------------------------------------------------------
package plti_pkg;

	// Operation codes carried on the op field
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// Status codes carried on the status field
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Sample and divider widths
	localparam int DATA_W    = 32;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Divide request: dividend upper half must be below the divisor
	typedef struct packed {
		logic                  start;
		logic [2*DATA_W-1:0]   dividend;
		logic [DATA_W-1:0]     divisor;
	} div_req_t;

	// Divide response: done pulses for one cycle with the quotient
	typedef struct packed {
		logic                  done;
		logic [DATA_W-1:0]     quotient;
	} div_rsp_t;

endpackage

// ----- src/plti_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_ram - generic single-port RAM
// One write or read per cycle at one address, read data registered.
// ----------------------------------------------------------------------------
module plti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/plti_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_div - iterative restoring divider
// Divides a 64-bit dividend by a 32-bit divisor, one quotient bit per cycle,
// for dividends whose quotient fits in 32 bits.
// ----------------------------------------------------------------------------
module plti_div
	import plti_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    low_q;
	logic [DATA_W-1:0]    div_q;
	logic [DATA_W:0]      trial;
	logic [DATA_W:0]      diff;
	logic                 qbit;

	// Trial subtract of the shifted remainder
	assign trial = {rem_q, low_q[DATA_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign qbit  = !diff[DATA_W];

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[2*DATA_W-1:DATA_W];
			low_q <= req.dividend[DATA_W-1:0];
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			low_q <= {low_q[DATA_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = low_q;

endmodule

// ----- src/piecewise_linear_table_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator - piecewise linear lookup over stored
// series of (time, value) points in signed Q16.16
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) takes one transaction: op clears a
//   series, appends a point, or queries the series at sample_time. Each
//   transaction yields exactly one output transaction (out_valid / out_stall)
//   carrying result_value and status.
//   One transaction is worked on at a time; in_stall stays high until its
//   result has moved into the output register, which then holds it while the
//   receiver stalls, so the next transaction can already be taken.
//   Clear and append go through the decode and response states to out_valid,
//   and the next transaction can be taken once the block is back in idle.
//   A query reads one stored point per cycle through the single memory port.
//   A miss responds once all points are read; a hit inside an interval runs
//   the 32x32 multiply and then the bit-serial divider (one quotient bit per
//   cycle) before the result is formed.
//   Reset clears all point counts, so every series starts empty; the point
//   memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator
	import plti_pkg::*;
#(
	parameter int NUM_SERIES   = 4,
	parameter int SERIES_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [1:0]         series_select,
	input  logic signed [31:0] sample_time,
	input  logic signed [31:0] sample_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic [1:0]         status
);

	localparam int SER_W  = (NUM_SERIES > 1) ? $clog2(NUM_SERIES) : 1;
	localparam int CNT_W  = $clog2(SERIES_DEPTH + 1);
	localparam int OFS_W  = $clog2(SERIES_DEPTH);
	localparam int MEM_D  = NUM_SERIES * SERIES_DEPTH;
	localparam int ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DECODE   = 7'b0000010,
		S_SCAN     = 7'b0000100,
		S_MUL      = 7'b0001000,
		S_DIV_GO   = 7'b0010000,
		S_DIV_WAIT = 7'b0100000,
		S_RESP     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Control registers
	logic [CNT_W-1:0]  count_q [NUM_SERIES];
	logic              out_valid_q;
	logic              rd_pend_q;
	logic              have_prev_q;
	logic [CNT_W-1:0]  rd_idx_q;

	// Payload registers
	logic [1:0]               op_q;
	logic [1:0]               sel_q;
	logic signed [DATA_W-1:0] t_q;
	logic signed [DATA_W-1:0] v_q;
	logic signed [DATA_W-1:0] prev_t_q;
	logic signed [DATA_W-1:0] prev_v_q;
	logic [DATA_W-1:0]        a_q;
	logic [DATA_W-1:0]        d_q;
	logic [DATA_W-1:0]        mag_q;
	logic                     neg_q;
	logic signed [DATA_W-1:0] v0_q;
	logic [2*DATA_W-1:0]      product_q;
	logic signed [DATA_W-1:0] res_value_q;
	logic [1:0]               res_status_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic [1:0]               out_status_q;

	// Series decode
	logic             sel_valid;
	logic [SER_W-1:0] sidx;
	logic [CNT_W-1:0] cur_cnt;
	logic             cnt_full;
	logic             cnt_short;

	assign sel_valid = 32'(sel_q) < 32'(NUM_SERIES);
	assign sidx      = SER_W'(sel_q);
	assign cur_cnt   = sel_valid ? count_q[sidx] : '0;
	assign cnt_full  = cur_cnt >= CNT_W'(SERIES_DEPTH);
	assign cnt_short = cur_cnt < CNT_W'(2);

	// Memory port
	logic                     ram_we;
	logic                     ram_re;
	logic [OFS_W-1:0]         ram_ofs;
	logic [ADDR_W-1:0]        ram_addr;
	logic signed [DATA_W-1:0] t1;
	logic signed [DATA_W-1:0] v1;
	logic                     rd_more;

	assign rd_more  = rd_idx_q < cur_cnt;
	assign ram_addr = ADDR_W'(32'(sidx) * SERIES_DEPTH + 32'(ram_ofs));

	always_comb begin
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		ram_ofs = '0;
		if (state_q == S_DECODE) begin
			if (op_q == OP_APPEND && sel_valid && !cnt_full) begin
				ram_we  = 1'b1;
				ram_ofs = cur_cnt[OFS_W-1:0];
			end else if (op_q == OP_QUERY) begin
				ram_re = 1'b1;
			end
		end else if (state_q == S_SCAN) begin
			ram_re  = rd_more;
			ram_ofs = rd_idx_q[OFS_W-1:0];
		end
	end

	plti_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MEM_D)
	) u_time_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (t_q),
		.rdata (t1)
	);

	plti_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MEM_D)
	) u_value_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (v_q),
		.rdata (v1)
	);

	// Interval test between the held point and the one just read
	logic              scan_eval;
	logic              hit_exact;
	logic              hit_rng;
	logic              scan_miss;
	logic [DATA_W:0]   dv;
	logic [DATA_W:0]   dv_neg;

	assign scan_eval = (state_q == S_SCAN) && rd_pend_q && have_prev_q;
	assign hit_exact = scan_eval && (prev_t_q == t_q);
	assign hit_rng   = scan_eval && (prev_t_q != t_q) && (prev_t_q <= t_q) && (t1 >= t_q);
	assign scan_miss = (state_q == S_SCAN) && !rd_pend_q;
	assign dv        = {v1[DATA_W-1], v1} - {prev_v_q[DATA_W-1], prev_v_q};
	assign dv_neg    = -dv;

	// Divider for the interpolation quotient
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign div_req.start    = (state_q == S_DIV_GO);
	assign div_req.dividend = product_q;
	assign div_req.divisor  = d_q;

	plti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (op_q == OP_QUERY && sel_valid && !cnt_short) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SCAN: begin
				if (hit_rng) begin
					state_d = S_MUL;
				end else if (hit_exact || scan_miss) begin
					state_d = S_RESP;
				end
			end
			S_MUL: begin
				state_d = S_DIV_GO;
			end
			S_DIV_GO: begin
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
			have_prev_q <= 1'b0;
			rd_idx_q    <= '0;
			for (int i = 0; i < NUM_SERIES; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			// Update the point count on clear and append
			if (state_q == S_DECODE && sel_valid) begin
				if (op_q == OP_CLEAR) begin
					count_q[sidx] <= '0;
				end else if (op_q == OP_APPEND && !cnt_full) begin
					count_q[sidx] <= cur_cnt + 1'b1;
				end
			end

			// Advance the scan read pointer
			if (state_q == S_DECODE) begin
				rd_pend_q   <= 1'b1;
				have_prev_q <= 1'b0;
				rd_idx_q    <= CNT_W'(1);
			end else if (state_q == S_SCAN) begin
				rd_pend_q <= rd_more;
				if (rd_more) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (rd_pend_q) begin
					have_prev_q <= 1'b1;
				end
			end

			// Output register handshake
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		// Capture the transaction
		if (state_q == S_IDLE && in_valid) begin
			op_q  <= op;
			sel_q <= series_select;
			t_q   <= sample_time;
			v_q   <= sample_value;
		end

		// Immediate results for clear, append and short or invalid queries
		if (state_q == S_DECODE) begin
			res_value_q <= '0;
			if (op_q == OP_APPEND && (!sel_valid || cnt_full)) begin
				res_status_q <= ST_FULL;
			end else if (op_q == OP_QUERY && (!sel_valid || cnt_short)) begin
				res_status_q <= ST_RANGE;
			end else begin
				res_status_q <= ST_OK;
			end
		end

		// Hold the previous point and latch interpolation operands
		if (state_q == S_SCAN && rd_pend_q) begin
			prev_t_q <= t1;
			prev_v_q <= v1;
		end
		if (hit_exact) begin
			res_value_q  <= prev_v_q;
			res_status_q <= ST_OK;
		end else if (hit_rng) begin
			a_q   <= DATA_W'(t_q - prev_t_q);
			d_q   <= DATA_W'(t1 - prev_t_q);
			neg_q <= dv[DATA_W];
			mag_q <= dv[DATA_W] ? dv_neg[DATA_W-1:0] : dv[DATA_W-1:0];
			v0_q  <= prev_v_q;
		end else if (scan_miss) begin
			res_value_q  <= '0;
			res_status_q <= ST_RANGE;
		end

		// Offset times slope numerator
		if (state_q == S_MUL) begin
			product_q <= a_q * mag_q;
		end

		// Apply the quotient to the interval start
		if (state_q == S_DIV_WAIT && div_rsp.done) begin
			res_value_q  <= neg_q ? v0_q - $signed(div_rsp.quotient)
				: v0_q + $signed(div_rsp.quotient);
			res_status_q <= ST_OK;
		end

		// Load the output register
		if (state_q == S_RESP && out_free) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_status_q;

endmodule

// ----- dv/tb_piecewise_linear_table_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interpolator - self-checking bench for the table
// interpolator
// Drives clear, append and query transactions on the input channel and checks
// every output transaction against a behavioral copy of the point stores,
// field by field and in order. A short directed part covers empty and
// one-point series, exact hits, interval ends, rounding toward zero, extreme
// Q16.16 values, unsorted points and the unused op code. One series is then
// filled past its depth, and random traffic builds sorted and unsorted series
// with random content and mixes in noise. The sender idles in bursts and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_table_interpolator;
	import plti_pkg::*;

	localparam int NUM_SERIES     = 4;
	localparam int SERIES_DEPTH   = 256;
	localparam int RANDOM_ITEMS   = 1250;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_TAIL     = 50;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam longint Q_MAX = 64'sd2147483647;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         op = OP_CLEAR;
	logic [1:0]         series_select = 2'd0;
	logic signed [31:0] sample_time = '0;
	logic signed [31:0] sample_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0]         status;

	// Behavioral copy of the point stores
	logic signed [31:0] pt_time [NUM_SERIES][SERIES_DEPTH];
	logic signed [31:0] pt_value [NUM_SERIES][SERIES_DEPTH];
	int unsigned        pt_count [NUM_SERIES];

	answer_t answers_due[$];

	int  fail_count = 0;
	int  results_checked = 0;
	int  items_sent = 0;
	int  burst_left = 1;
	bit  gaps_on = 1'b1;
	int  idle_cycles = 0;
	int  n_clear = 0, n_append = 0, n_query = 0, n_unused = 0;
	int  n_interp = 0, n_exact = 0, n_range = 0, n_full = 0;

	// Stall pattern state
	int  stall_mode = 0;
	int  stall_phase = 0;
	int  stall_hold = 0;

	piecewise_linear_table_interpolator #(
		.NUM_SERIES   (NUM_SERIES),
		.SERIES_DEPTH (SERIES_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.series_select (series_select),
		.sample_time   (sample_time),
		.sample_value  (sample_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_value  (result_value),
		.status        (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one transaction to the stores and return the answer it yields
	function automatic answer_t compute_answer(input logic [1:0] op_i, input logic [1:0] sel_i,
			input logic signed [31:0] t_i, input logic signed [31:0] v_i);
		answer_t     r;
		int unsigned n;
		longint      t, t0, t1, v0, v1, dv, res;
		bit [63:0]   a, d, mag, q;
		bit          hit;
		r.value  = '0;
		r.status = ST_OK;
		hit      = 1'b0;
		t        = longint'(t_i);
		case (op_i)
			OP_CLEAR: begin
				n_clear++;
				if (sel_i < NUM_SERIES)
					pt_count[sel_i] = 0;
			end
			OP_APPEND: begin
				n_append++;
				if (sel_i >= NUM_SERIES || pt_count[sel_i] >= SERIES_DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					pt_time[sel_i][pt_count[sel_i]]  = t_i;
					pt_value[sel_i][pt_count[sel_i]] = v_i;
					pt_count[sel_i]++;
				end
			end
			OP_QUERY: begin
				n_query++;
				n = (sel_i < NUM_SERIES) ? pt_count[sel_i] : 0;
				// Scan intervals in stored order, first match wins
				for (int i = 1; i < n && !hit; i++) begin
					t0 = longint'(pt_time[sel_i][i-1]);
					t1 = longint'(pt_time[sel_i][i]);
					v0 = longint'(pt_value[sel_i][i-1]);
					v1 = longint'(pt_value[sel_i][i]);
					if (t0 == t) begin
						r.value = v0[31:0];
						hit = 1'b1;
						n_exact++;
					end else if (t0 <= t && t1 >= t) begin
						a   = t - t0;
						d   = t1 - t0;
						dv  = v1 - v0;
						mag = (dv < 0) ? -dv : dv;
						q   = (a * mag) / d;
						res = (dv < 0) ? v0 - longint'(q) : v0 + longint'(q);
						r.value = res[31:0];
						hit = 1'b1;
						n_interp++;
					end
				end
				if (!hit) begin
					r.status = ST_RANGE;
					n_range++;
				end
			end
			default: n_unused++;
		endcase
		return r;
	endfunction

	// Send one transaction, hold it until accepted, then idle per the burst plan
	task automatic send_item(input logic [1:0] op_i, input logic [1:0] sel_i,
			input logic signed [31:0] t_i, input logic signed [31:0] v_i);
		int unsigned gap;
		in_valid      <= 1'b1;
		op            <= op_i;
		series_select <= sel_i;
		sample_time   <= t_i;
		sample_value  <= v_i;
		do @(posedge clk); while (in_stall);
		answers_due.push_back(compute_answer(op_i, sel_i, t_i, v_i));
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = 0;
			if (gaps_on)
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
					: $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and hold off until every outstanding answer has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic longint clamp_q(input longint x);
		if (x < Q_MIN)
			return Q_MIN;
		if (x > Q_MAX)
			return Q_MAX;
		return x;
	endfunction

	// Pick a query time that lands on points, inside intervals, or beyond the ends
	function automatic logic signed [31:0] pick_query_time(input logic [1:0] s);
		int unsigned n, i;
		longint      t0, t1, t;
		n = pt_count[s];
		t = longint'($signed($urandom));
		if (n != 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2: t = longint'(pt_time[s][$urandom_range(0, n - 1)]);
				3, 4, 5, 6: begin
					i  = (n > 1) ? $urandom_range(1, n - 1) : 0;
					t0 = longint'(pt_time[s][(i == 0) ? 0 : i - 1]);
					t1 = longint'(pt_time[s][i]);
					t  = (t1 > t0) ? t0 + (longint'($urandom) % (t1 - t0 + 1)) : t0;
				end
				7: t = clamp_q(longint'(pt_time[s][0]) - $urandom_range(1, 70000));
				8: t = clamp_q(longint'(pt_time[s][n - 1]) + $urandom_range(1, 70000));
				default: ;
			endcase
		end
		return t[31:0];
	endfunction

	// Clear a series, append sorted points, then query it
	task automatic run_sorted_sequence(input logic [1:0] s);
		int unsigned n, step_max;
		longint      t, v, vbase;
		bit          wide_values;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
		case ($urandom_range(0, 2))
			0: step_max = 16;
			1: step_max = 65535;
			default: step_max = 1 << 24;
		endcase
		t = longint'($signed($urandom));
		if (t > Q_MAX - longint'(n) * longint'(step_max))
			t = Q_MAX - longint'(n) * longint'(step_max);
		wide_values = 1'($urandom_range(0, 1));
		vbase = longint'($signed($urandom)) / 256;
		send_item(OP_CLEAR, s, $urandom, $urandom);
		repeat (n) begin
			v = wide_values ? longint'($signed($urandom))
				: vbase + longint'($urandom_range(0, 4096)) - 2048;
			send_item(OP_APPEND, s, t[31:0], v[31:0]);
			t += $urandom_range(0, step_max);
		end
		repeat ($urandom_range(3, 10))
			send_item(OP_QUERY, s, pick_query_time(s), $urandom);
	endtask

	// Clear a series, append points in random order within a window, query it
	task automatic run_unsorted_sequence(input logic [1:0] s);
		longint base, t;
		base = clamp_q(longint'($signed($urandom)) - 4000);
		send_item(OP_CLEAR, s, $urandom, $urandom);
		repeat ($urandom_range(2, 8)) begin
			t = base + $urandom_range(0, 4000);
			send_item(OP_APPEND, s, t[31:0], $urandom);
		end
		repeat ($urandom_range(3, 8))
			send_item(OP_QUERY, s, pick_query_time(s), $urandom);
	endtask

	// Fire unrelated transactions with fully random fields
	task automatic run_noise();
		logic [1:0] op_r;
		repeat ($urandom_range(3, 12)) begin
			op_r = ($urandom_range(0, 49) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
			send_item(op_r, 2'($urandom_range(0, 3)), $urandom, $urandom);
		end
	endtask

	// Empty and one-point series, exact hits, interval ends, rounding of negative slopes
	task automatic test_empty_and_short_series();
		send_item(OP_QUERY, 2'd1, 32'sd0, $urandom);
		send_item(OP_APPEND, 2'd1, 32'sd0, 32'sd0);
		send_item(OP_QUERY, 2'd1, 32'sd0, $urandom);
		send_item(OP_APPEND, 2'd1, 32'sd3, -32'sd10);
		send_item(OP_QUERY, 2'd1, 32'sd0, $urandom);
		send_item(OP_QUERY, 2'd1, 32'sd1, $urandom);
		send_item(OP_QUERY, 2'd1, 32'sd2, $urandom);
		send_item(OP_QUERY, 2'd1, 32'sd3, $urandom);
		send_item(OP_CLEAR, 2'd1, $urandom, $urandom);
		send_item(OP_QUERY, 2'd1, 32'sd1, $urandom);
	endtask

	// Full-scale interval: extreme times and values, widest product
	task automatic test_interpolation_extremes();
		send_item(OP_CLEAR, 2'd2, 32'sh7fff_ffff, 32'sh8000_0000);
		send_item(OP_APPEND, 2'd2, 32'sh8000_0000, 32'sh7fff_ffff);
		send_item(OP_APPEND, 2'd2, 32'sh7fff_ffff, 32'sh8000_0000);
		send_item(OP_QUERY, 2'd2, 32'sh8000_0000, 32'sh7fff_ffff);
		send_item(OP_QUERY, 2'd2, 32'sh7fff_ffff, 32'sh8000_0000);
		send_item(OP_QUERY, 2'd2, 32'sd0, $urandom);
		send_item(OP_QUERY, 2'd2, 32'sh8000_0001, $urandom);
	endtask

	// Points out of order: first matching interval wins; unused op is a no-op
	task automatic test_unsorted_and_unused_op();
		send_item(OP_CLEAR, 2'd3, $urandom, $urandom);
		send_item(OP_APPEND, 2'd3, 32'sd100, 32'sd10);
		send_item(OP_APPEND, 2'd3, 32'sd50, 32'sd20);
		send_item(OP_APPEND, 2'd3, 32'sd200, 32'sd30);
		send_item(OP_QUERY, 2'd3, 32'sd75, $urandom);
		send_item(OP_QUERY, 2'd3, 32'sd100, $urandom);
		send_item(OP_QUERY, 2'd3, 32'sd150, $urandom);
		send_item(OP_QUERY, 2'd3, 32'sd200, $urandom);
		send_item(OP_QUERY, 2'd3, 32'sd40, $urandom);
		send_item(OP_UNUSED, 2'($urandom_range(0, 3)), $urandom, $urandom);
	endtask

	// Fill one series to its depth, append past it, then query deep into it
	task automatic test_series_overflow();
		logic [1:0] s;
		longint     t;
		s = 2'($urandom_range(0, 3));
		t = clamp_q(longint'($signed($urandom)));
		if (t > Q_MAX - longint'(SERIES_DEPTH) * 4096)
			t = Q_MAX - longint'(SERIES_DEPTH) * 4096;
		send_item(OP_CLEAR, s, $urandom, $urandom);
		repeat (SERIES_DEPTH) begin
			send_item(OP_APPEND, s, t[31:0], $urandom);
			t += $urandom_range(1, 4096);
		end
		repeat (3)
			send_item(OP_APPEND, s, t[31:0], $urandom);
		send_item(OP_QUERY, s, pt_time[s][SERIES_DEPTH - 1], $urandom);
		repeat (5)
			send_item(OP_QUERY, s, pick_query_time(s), $urandom);
	endtask

	// Sender holds off until the block has answered everything, then resumes
	task automatic test_drain_pause();
		gaps_on = 1'b0;
		run_sorted_sequence(2'd0);
		wait_drained();
		run_sorted_sequence(2'd1);
		gaps_on = 1'b1;
	endtask

	// Mostly well-formed series with random content, plus noise and drain pauses
	task automatic test_random_traffic();
		int start, pick;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			gaps_on = ($urandom_range(0, 9) < 7);
			pick = $urandom_range(0, 99);
			if (pick < 65)
				run_sorted_sequence(2'($urandom_range(0, 3)));
			else if (pick < 80)
				run_unsorted_sequence(2'($urandom_range(0, 3)));
			else if (pick < 97)
				run_noise();
			else
				wait_drained();
		end
		gaps_on = 1'b1;
	endtask

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("MISMATCH: %s", what);
	endtask

	// Check each output transaction against the oldest outstanding answer
	always @(posedge clk) begin
		answer_t due;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (answers_due.size() == 0) begin
				note_failure($sformatf("unexpected result: value %h status %0d",
					result_value, status));
			end else begin
				due = answers_due.pop_front();
				if (result_value !== due.value || status !== due.status)
					note_failure($sformatf({"result %0d: expected value %h status %0d,",
						" got value %h status %0d"},
						results_checked, due.value, due.status, result_value, status));
			end
		end
	end

	// Receiver stall pattern: phases of no stall, random stall, and long stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall   <= 1'b0;
			stall_mode  <= 0;
			stall_phase <= 0;
			stall_hold  <= 0;
		end else begin
			if (stall_phase == 0) begin
				stall_mode  <= $urandom_range(0, 2);
				stall_phase <= $urandom_range(50, 400);
			end else begin
				stall_phase <= stall_phase - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 35);
				default: begin
					if (stall_hold != 0) begin
						stall_hold <= stall_hold - 1;
					end else begin
						out_stall  <= ~out_stall;
						stall_hold <= out_stall ? $urandom_range(0, 6) : $urandom_range(0, 20);
					end
				end
			endcase
		end
	end

	// End the run when neither channel moves a transaction for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d answers outstanding",
				idle_cycles, answers_due.size());
			$display("piecewise_linear_table_interpolator verification failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_short_series();
		test_interpolation_extremes();
		test_unsorted_and_unused_op();
		wait_drained();
		test_series_overflow();
		test_drain_pause();
		test_random_traffic();

		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);

		$display({"covered %0d transactions (%0d clear, %0d append, %0d query,",
			" %0d unused op), %0d results checked"},
			items_sent, n_clear, n_append, n_query, n_unused, results_checked);
		$display({"queries: %0d interpolated, %0d exact point, %0d out of range;",
			" %0d appends dropped as full"},
			n_interp, n_exact, n_range, n_full);
		if (fail_count == 0 && answers_due.size() == 0) begin
			$display("piecewise_linear_table_interpolator verification clean");
		end else begin
			$display("%0d mismatches, %0d answers never arrived", fail_count, answers_due.size());
			$display("piecewise_linear_table_interpolator verification failed");
		end
		$finish;
	end

endmodule

// ----- piecewise_linear_table_interpolator.f -----
src/plti_pkg.sv
src/plti_ram.sv
src/plti_div.sv
src/piecewise_linear_table_interpolator.sv
dv/tb_piecewise_linear_table_interpolator.sv
